@@ hdl/msd_pkg.sv @@
// Shared types, constants and helpers for the motion settle detector.
// No dependencies; every other file of the block imports this package.
package msd_pkg;

  localparam int TIME_W = 32;
  localparam int SPD_W  = 16;
  localparam int STEP_W = 16;
  localparam int CNT_W  = 10;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // APB-style register port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  // Body counts stop at the smaller of the body limit and the count field range
  localparam int MAX_BODIES = 1023;
  localparam int CNT_MAX    = (1 << CNT_W) - 1;
  localparam int CAP_INT    = (MAX_BODIES < CNT_MAX) ? MAX_BODIES : CNT_MAX;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

  // Command queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register reset values and lower clamps
  localparam logic [SPD_W-1:0]  LIN_LIMIT_RST = SPD_W'(5);
  localparam logic [SPD_W-1:0]  ANG_LIMIT_RST = SPD_W'(5);
  localparam logic [TIME_W-1:0] HOLD_RST      = TIME_W'(500);
  localparam logic [TIME_W-1:0] POST_RST      = TIME_W'(250);
  localparam logic [TIME_W-1:0] MAX_WAIT_RST  = TIME_W'(10000);
  localparam logic [STEP_W-1:0] INTERVAL_RST  = STEP_W'(100);
  localparam logic [TIME_W-1:0] MAX_WAIT_MIN  = TIME_W'(100);
  localparam logic [STEP_W-1:0] INTERVAL_MIN  = STEP_W'(10);

  typedef enum logic [IDX_W-1:0] {
    REG_LIN_LIMIT = 3'd0,
    REG_ANG_LIMIT = 3'd1,
    REG_HOLD      = 3'd2,
    REG_POST      = 3'd3,
    REG_MAX_WAIT  = 3'd4,
    REG_INTERVAL  = 3'd5
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET = 3'd0,
    CMD_BEGIN = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_BODY  = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    OP_RESET,
    OP_BEGIN,
    OP_MARK,
    OP_BODY,
    OP_TICK
  } op_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_MONITOR = 2'd0,
    ST_SETTLED = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] time_now;
    logic [STEP_W-1:0] step_ms;
    logic [SPD_W-1:0]  linear_speed;
    logic [SPD_W-1:0]  angular_speed;
    logic              body_live;
    logic              body_awake;
  } msd_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  active_count;
    logic [CNT_W-1:0]  moving_count;
    logic [CNT_W-1:0]  awake_count;
    logic [SPD_W-1:0]  max_linear;
    logic [SPD_W-1:0]  max_angular;
    logic [TIME_W-1:0] stable_ms;
    logic [TIME_W-1:0] since_activity_ms;
    logic [TIME_W-1:0] elapsed_ms;
  } msd_out_t;

  typedef struct packed {
    logic [SPD_W-1:0]  lin_limit;
    logic [SPD_W-1:0]  ang_limit;
    logic [TIME_W-1:0] hold_ms;
    logic [TIME_W-1:0] post_ms;
    logic [TIME_W-1:0] max_wait_ms;
    logic [STEP_W-1:0] interval_ms;
  } msd_cfg_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    op_kind_t          kind;
    logic [TIME_W-1:0] time_now;
    logic [STEP_W-1:0] step_ms;
    logic [SPD_W-1:0]  lin;
    logic [SPD_W-1:0]  ang;
    logic              awake;
    logic              moving;
  } msd_op_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] diff_clamp(input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] then_t);
    return (now >= then_t) ? (now - then_t) : '0;
  endfunction

endpackage

@@ hdl/msd_regs.sv @@
// Configuration registers behind the APB-style port, with write-time clamps.
// Depends on msd_pkg.
module msd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msd_pkg::ADDR_W-1:0]   paddr,
  input  logic [msd_pkg::DATA_W-1:0]   pwdata,
  output logic [msd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output msd_pkg::msd_cfg_t            cfg
);
  import msd_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic              wr_en;
  logic [STEP_W-1:0] wdata16;

  assign pready  = 1'b1;
  assign idx     = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign wdata16 = pwdata[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lin_limit   <= LIN_LIMIT_RST;
      cfg.ang_limit   <= ANG_LIMIT_RST;
      cfg.hold_ms     <= HOLD_RST;
      cfg.post_ms     <= POST_RST;
      cfg.max_wait_ms <= MAX_WAIT_RST;
      cfg.interval_ms <= INTERVAL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LIN_LIMIT: cfg.lin_limit <= pwdata[SPD_W-1:0];
        REG_ANG_LIMIT: cfg.ang_limit <= pwdata[SPD_W-1:0];
        REG_HOLD:      cfg.hold_ms   <= pwdata;
        REG_POST:      cfg.post_ms   <= pwdata;
        REG_MAX_WAIT:  cfg.max_wait_ms <= (pwdata < MAX_WAIT_MIN) ? MAX_WAIT_MIN : pwdata;
        REG_INTERVAL:  cfg.interval_ms <= (wdata16 < INTERVAL_MIN) ? INTERVAL_MIN : wdata16;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIN_LIMIT: prdata = DATA_W'(cfg.lin_limit);
      REG_ANG_LIMIT: prdata = DATA_W'(cfg.ang_limit);
      REG_HOLD:      prdata = cfg.hold_ms;
      REG_POST:      prdata = cfg.post_ms;
      REG_MAX_WAIT:  prdata = cfg.max_wait_ms;
      REG_INTERVAL:  prdata = DATA_W'(cfg.interval_ms);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/msd_front.sv @@
// Front end: decode input items, drop those with no effect, tag moving bodies.
// Depends on msd_pkg.
module msd_front (
  input  msd_pkg::msd_in_t  item,
  input  logic              item_valid,
  output logic              item_stall,
  input  msd_pkg::msd_cfg_t cfg,
  input  logic              q_full,
  output logic              push,
  output msd_pkg::msd_op_t  op
);
  import msd_pkg::*;

  logic keep;

  assign item_stall = q_full;

  always_comb begin
    keep    = 1'b1;
    op.kind = OP_TICK;
    unique case (item.cmd)
      CMD_RESET: op.kind = OP_RESET;
      CMD_BEGIN: op.kind = OP_BEGIN;
      CMD_MARK:  op.kind = OP_MARK;
      CMD_BODY: begin
        op.kind = OP_BODY;
        keep    = item.body_live;
      end
      CMD_TICK:  op.kind = OP_TICK;
      default:   keep = 1'b0;
    endcase
    op.time_now = item.time_now;
    op.step_ms  = item.step_ms;
    op.lin      = item.linear_speed;
    op.ang      = item.angular_speed;
    op.awake    = item.body_awake;
    op.moving   = (item.linear_speed > cfg.lin_limit) ||
                  (item.angular_speed > cfg.ang_limit);
  end

  assign push = item_valid && !q_full && keep;

endmodule

@@ hdl/msd_queue.sv @@
// Short command queue between the front end and the execution back end.
// Depends on msd_pkg.
module msd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msd_pkg::msd_op_t push_op,
  input  logic             pop,
  output logic             head_valid,
  output msd_pkg::msd_op_t head_op,
  output logic             full
);
  import msd_pkg::*;

  msd_op_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/msd_back.sv @@
// Back end: execute queued commands on the settle state and register results.
// Depends on msd_pkg.
module msd_back (
  input  logic              clk,
  input  logic              rst,
  input  msd_pkg::msd_cfg_t cfg,
  input  logic              head_valid,
  input  msd_pkg::msd_op_t  head_op,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output msd_pkg::msd_out_t result
);
  import msd_pkg::*;

  logic              settling, settling_next;
  logic [TIME_W-1:0] last_act, last_act_next;
  logic [TIME_W-1:0] start_t, start_t_next;
  logic [TIME_W-1:0] acc, acc_next;
  logic [TIME_W-1:0] stable, stable_next;
  logic [CNT_W-1:0]  sum_active, sum_active_next;
  logic [CNT_W-1:0]  sum_moving, sum_moving_next;
  logic [CNT_W-1:0]  sum_awake, sum_awake_next;
  logic [SPD_W-1:0]  sum_lin, sum_lin_next;
  logic [SPD_W-1:0]  sum_ang, sum_ang_next;
  logic [TIME_W-1:0] sum_stable, sum_stable_next;
  logic [TIME_W-1:0] sum_since, sum_since_next;
  logic [TIME_W-1:0] sum_elapsed, sum_elapsed_next;
  logic [CNT_W-1:0]  pend_active, pend_active_next;
  logic [CNT_W-1:0]  pend_moving, pend_moving_next;
  logic [CNT_W-1:0]  pend_awake, pend_awake_next;
  logic [SPD_W-1:0]  pend_lin, pend_lin_next;
  logic [SPD_W-1:0]  pend_ang, pend_ang_next;

  logic              is_tick;
  logic              fire;
  status_t           status;
  logic [TIME_W-1:0] since_c;
  logic [TIME_W-1:0] elapsed_c;
  logic [TIME_W-1:0] acc_sum;
  logic [TIME_W-1:0] stable_sum;
  logic              newer;

  // A tick needs the result register free; other commands never wait
  assign is_tick = (head_op.kind == OP_TICK);
  assign pop     = head_valid && (!is_tick || !result_valid || !result_stall);
  assign fire    = pop && is_tick;

  assign since_c    = diff_clamp(head_op.time_now, last_act);
  assign elapsed_c  = diff_clamp(head_op.time_now, start_t);
  assign acc_sum    = sat_add(acc, TIME_W'(head_op.step_ms));
  assign stable_sum = sat_add(stable, acc_sum);
  assign newer      = (head_op.time_now > last_act);

  always_comb begin
    settling_next    = settling;
    last_act_next    = last_act;
    start_t_next     = start_t;
    acc_next         = acc;
    stable_next      = stable;
    sum_active_next  = sum_active;
    sum_moving_next  = sum_moving;
    sum_awake_next   = sum_awake;
    sum_lin_next     = sum_lin;
    sum_ang_next     = sum_ang;
    sum_stable_next  = sum_stable;
    sum_since_next   = sum_since;
    sum_elapsed_next = sum_elapsed;
    pend_active_next = pend_active;
    pend_moving_next = pend_moving;
    pend_awake_next  = pend_awake;
    pend_lin_next    = pend_lin;
    pend_ang_next    = pend_ang;
    status           = ST_MONITOR;

    if (pop) begin
      unique case (head_op.kind)
        OP_RESET: begin
          sum_active_next  = '0;
          sum_moving_next  = '0;
          sum_awake_next   = '0;
          sum_lin_next     = '0;
          sum_ang_next     = '0;
          sum_stable_next  = '0;
          sum_since_next   = '0;
          sum_elapsed_next = '0;
          pend_active_next = '0;
          pend_moving_next = '0;
          pend_awake_next  = '0;
          pend_lin_next    = '0;
          pend_ang_next    = '0;
          last_act_next    = head_op.time_now;
          start_t_next     = head_op.time_now;
          acc_next         = '0;
          stable_next      = '0;
          settling_next    = 1'b0;
        end
        OP_BEGIN: begin
          start_t_next  = head_op.time_now;
          acc_next      = TIME_W'(cfg.interval_ms);
          stable_next   = '0;
          settling_next = 1'b1;
          if (newer) begin
            last_act_next   = head_op.time_now;
            sum_stable_next = '0;
          end
        end
        OP_MARK: begin
          if (newer) begin
            last_act_next   = head_op.time_now;
            stable_next     = '0;
            sum_stable_next = '0;
          end
        end
        OP_BODY: begin
          if (pend_active < COUNT_CAP) begin
            pend_active_next = pend_active + 1'b1;
          end
          if (head_op.awake && (pend_awake < COUNT_CAP)) begin
            pend_awake_next = pend_awake + 1'b1;
          end
          if (head_op.moving && (pend_moving < COUNT_CAP)) begin
            pend_moving_next = pend_moving + 1'b1;
          end
          if (head_op.lin > pend_lin) begin
            pend_lin_next = head_op.lin;
          end
          if (head_op.ang > pend_ang) begin
            pend_ang_next = head_op.ang;
          end
        end
        OP_TICK: begin
          // Every tick starts a fresh pending sample
          pend_active_next = '0;
          pend_moving_next = '0;
          pend_awake_next  = '0;
          pend_lin_next    = '0;
          pend_ang_next    = '0;
          if (settling) begin
            sum_since_next   = since_c;
            sum_elapsed_next = elapsed_c;
            priority if (elapsed_c >= cfg.max_wait_ms) begin
              status = ST_TIMEOUT;
            end else if (acc_sum < TIME_W'(cfg.interval_ms)) begin
              acc_next = acc_sum;
            end else begin
              acc_next        = '0;
              sum_active_next = pend_active;
              sum_moving_next = pend_moving;
              sum_awake_next  = pend_awake;
              sum_lin_next    = pend_lin;
              sum_ang_next    = pend_ang;
              stable_next     = (pend_moving == '0) ? stable_sum : '0;
              sum_stable_next = stable_next;
              if ((stable_next >= cfg.hold_ms) && (since_c >= cfg.post_ms)) begin
                status = ST_SETTLED;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settling    <= 1'b0;
      last_act    <= '0;
      start_t     <= '0;
      acc         <= '0;
      stable      <= '0;
      sum_active  <= '0;
      sum_moving  <= '0;
      sum_awake   <= '0;
      sum_lin     <= '0;
      sum_ang     <= '0;
      sum_stable  <= '0;
      sum_since   <= '0;
      sum_elapsed <= '0;
      pend_active <= '0;
      pend_moving <= '0;
      pend_awake  <= '0;
      pend_lin    <= '0;
      pend_ang    <= '0;
    end else begin
      settling    <= settling_next;
      last_act    <= last_act_next;
      start_t     <= start_t_next;
      acc         <= acc_next;
      stable      <= stable_next;
      sum_active  <= sum_active_next;
      sum_moving  <= sum_moving_next;
      sum_awake   <= sum_awake_next;
      sum_lin     <= sum_lin_next;
      sum_ang     <= sum_ang_next;
      sum_stable  <= sum_stable_next;
      sum_since   <= sum_since_next;
      sum_elapsed <= sum_elapsed_next;
      pend_active <= pend_active_next;
      pend_moving <= pend_moving_next;
      pend_awake  <= pend_awake_next;
      pend_lin    <= pend_lin_next;
      pend_ang    <= pend_ang_next;
    end
  end

  // Result register: load on a tick, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.status            <= status;
      result.active_count      <= sum_active_next;
      result.moving_count      <= sum_moving_next;
      result.awake_count       <= sum_awake_next;
      result.max_linear        <= sum_lin_next;
      result.max_angular       <= sum_ang_next;
      result.stable_ms         <= sum_stable_next;
      result.since_activity_ms <= sum_since_next;
      result.elapsed_ms        <= sum_elapsed_next;
    end
  end

endmodule

@@ hdl/motion_settle_detector.sv @@
// Motion settle detector top level: register port, front end, queue, back end.
// Depends on msd_pkg, msd_regs, msd_front, msd_queue and msd_back.
//
// Usage:
//   Items arrive on item / item_valid / item_stall. Each item is a reset,
//   begin, activity mark, body sample or tick command. Body samples fold
//   into a pending sample; every tick yields one request on result /
//   result_valid / result_stall with the status and the sample summary.
//   Other commands produce nothing on the result channel.
//   Throughput: one item per cycle, bodies and ticks alike, unless a tick
//   waits on a stalled receiver. A tick passes through the command queue to
//   the result register; the four-entry command queue sets the slack. The
//   front end only decodes and tags bodies as moving; the back end executes
//   one queued command per cycle on the settle state. When the receiver
//   stalls, the result register holds its request; body and control commands
//   keep draining, and a tick waits at the queue head until the register
//   frees. item_stall rises only when the queue is full. Reset (rst,
//   synchronous) empties the queue, clears the settle state and the result
//   valid, and loads register defaults. The user must write registers through
//   the APB-style port only while no command is in flight; unchecked.
module motion_settle_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  msd_pkg::msd_in_t            item,
  input  logic                        item_valid,
  output logic                        item_stall,
  output msd_pkg::msd_out_t           result,
  output logic                        result_valid,
  input  logic                        result_stall,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msd_pkg::ADDR_W-1:0]  paddr,
  input  logic [msd_pkg::DATA_W-1:0]  pwdata,
  output logic [msd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import msd_pkg::*;

  msd_cfg_t cfg;
  msd_op_t  push_op;
  msd_op_t  head_op;
  logic     push;
  logic     pop;
  logic     head_valid;
  logic     q_full;

  // Registers: limits, hold times, timeout and sample interval
  msd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Decode and drop unknown commands and bodies that are not live
  msd_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .op         (push_op)
  );

  // Decouple acceptance from execution so each side stalls on its own
  msd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .full       (q_full)
  );

  // Execute commands in order and hold results for the receiver
  msd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ hdl/msd_checker.sv @@
// Port-level checks for the motion settle detector, bound to the top level.
// Depends on msd_pkg and motion_settle_detector.
module msd_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input msd_pkg::msd_out_t result
);
  import msd_pkg::*;

  // No request survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Moving and awake bodies are always a subset of live bodies
  a_counts: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> (result.moving_count <= result.active_count) &&
                       (result.awake_count <= result.active_count))
    else $error("sample counts inconsistent");

  // Timeout needs at least the smallest allowed wait to have passed
  a_timeout: assert property (@(posedge clk) disable iff (rst)
      result_valid && (result.status == ST_TIMEOUT) |-> result.elapsed_ms >= MAX_WAIT_MIN)
    else $error("timeout reported too early");

endmodule

bind motion_settle_detector msd_checker u_msd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ verif/motion_settle_detector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for motion_settle_detector: directed rows, then random
// settle sequences under several register settings, checked against a local predictor.
// Depends on msd_pkg and the motion_settle_detector RTL only.
module motion_settle_detector_tb;
  import msd_pkg::*;

  // Unused command codes; the block must drop them without a report
  localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;
  // Cycles with no handshake on either channel before the run is abandoned
  localparam int STALL_LIMIT = 5000;
  // Queue depth plus pipeline, with margin: settle time before a register write
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst;
  msd_in_t               item;
  logic                  item_valid;
  logic                  item_stall;
  msd_out_t              result;
  logic                  result_valid;
  logic                  result_stall;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  motion_settle_detector uut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Settle predictor: register copies, settle state and the reports it owes
  // ---------------------------------------------------------------------------
  logic [SPD_W-1:0]  lin_limit_cfg;
  logic [SPD_W-1:0]  ang_limit_cfg;
  logic [TIME_W-1:0] hold_cfg;
  logic [TIME_W-1:0] post_cfg;
  logic [TIME_W-1:0] max_wait_cfg;
  logic [STEP_W-1:0] interval_cfg;

  logic              settling_m;
  logic [TIME_W-1:0] last_activity_m;
  logic [TIME_W-1:0] start_m;
  logic [TIME_W-1:0] accum_m;
  logic [TIME_W-1:0] stable_m;
  msd_out_t          shown_m;      // summary as the next tick reports it
  logic [CNT_W-1:0]  pend_active;
  logic [CNT_W-1:0]  pend_moving;
  logic [CNT_W-1:0]  pend_awake;
  logic [SPD_W-1:0]  pend_lin;
  logic [SPD_W-1:0]  pend_ang;

  msd_out_t          reports_due[$];
  int                mismatches;
  int                work_items;   // requests the block acts on (ignored ones excluded)
  bit                no_gaps;
  logic [TIME_W-1:0] world_ms;
  int                idle_cycles;

  typedef struct {
    msd_in_t  req;
    bit       pinned;
    msd_out_t report;
  } dir_row_t;

  dir_row_t directed_rows[$];

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got)
      flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endfunction

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic void drop_pending();
    pend_active = '0;
    pend_moving = '0;
    pend_awake  = '0;
    pend_lin    = '0;
    pend_ang    = '0;
  endfunction

  // A mark only counts when it is strictly later than the last one
  function automatic void take_mark(input logic [TIME_W-1:0] now);
    if (now > last_activity_m) begin
      last_activity_m   = now;
      stable_m          = '0;
      shown_m.stable_ms = '0;
    end
  endfunction

  // Advance the predictor by one accepted request; fired marks a tick report
  task automatic predict_settle(input msd_in_t r, output bit fired);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] dur;
    now   = r.time_now;
    fired = 1'b0;
    case (r.cmd)
      CMD_RESET: begin
        shown_m = '0;
        drop_pending();
        last_activity_m = now;
        start_m         = now;
        accum_m         = '0;
        stable_m        = '0;
        settling_m      = 1'b0;
        work_items++;
      end
      CMD_BEGIN: begin
        // preload so the first tick after begin samples unless it times out
        start_m    = now;
        accum_m    = {16'd0, interval_cfg};
        stable_m   = '0;
        settling_m = 1'b1;
        take_mark(now);
        work_items++;
      end
      CMD_MARK: begin
        take_mark(now);
        work_items++;
      end
      CMD_BODY: begin
        if (r.body_live) begin
          if (pend_active < COUNT_CAP) pend_active++;
          if (r.linear_speed > pend_lin) pend_lin = r.linear_speed;
          if (r.angular_speed > pend_ang) pend_ang = r.angular_speed;
          if (r.body_awake && pend_awake < COUNT_CAP) pend_awake++;
          if ((r.linear_speed > lin_limit_cfg || r.angular_speed > ang_limit_cfg) &&
              pend_moving < COUNT_CAP)
            pend_moving++;
          work_items++;
        end
      end
      CMD_TICK: begin
        fired = 1'b1;
        work_items++;
        shown_m.status = ST_MONITOR;
        if (settling_m) begin
          shown_m.since_activity_ms = (now >= last_activity_m) ? now - last_activity_m : '0;
          shown_m.elapsed_ms        = (now >= start_m) ? now - start_m : '0;
          if (shown_m.elapsed_ms >= max_wait_cfg) begin
            // timed out: accumulator and stable time are frozen
            shown_m.status = ST_TIMEOUT;
          end else begin
            accum_m = sat_sum(accum_m, {16'd0, r.step_ms});
            if (accum_m >= interval_cfg) begin
              dur     = accum_m;
              accum_m = '0;
              shown_m.active_count = pend_active;
              shown_m.moving_count = pend_moving;
              shown_m.awake_count  = pend_awake;
              shown_m.max_linear   = pend_lin;
              shown_m.max_angular  = pend_ang;
              stable_m = (pend_moving == '0) ? sat_sum(stable_m, dur) : '0;
              shown_m.stable_ms = stable_m;
              if (stable_m >= hold_cfg && shown_m.since_activity_ms >= post_cfg)
                shown_m.status = ST_SETTLED;
            end
          end
        end
        // every tick starts a fresh pending sample
        drop_pending();
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic msd_in_t rand_item();
    msd_in_t r;
    r.cmd           = CMD_W'($urandom_range(0, 7));
    r.time_now      = $urandom;
    r.step_ms       = STEP_W'($urandom);
    r.linear_speed  = SPD_W'($urandom);
    r.angular_speed = SPD_W'($urandom);
    r.body_live     = 1'($urandom);
    r.body_awake    = 1'($urandom);
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  // A pinned row queues its typed-in report instead of the predicted one.
  task automatic send_pinned(input msd_in_t r, input bit pinned, input msd_out_t pin_rep);
    int gap;
    bit fired;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= r;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_settle(r, fired);
    if (fired) reports_due.push_back(pinned ? pin_rep : shown_m);
    @(negedge clk);
  endtask

  task automatic send(input msd_in_t r);
    send_pinned(r, 1'b0, '0);
  endtask

  // One APB transfer from a falling edge; returns with psel and penable low
  task automatic apb_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register, mirror it in the predictor with its clamp, read it back
  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] stored;
    logic [DATA_W-1:0] got;
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'(idx) << 2;
    case (idx)
      REG_LIN_LIMIT: stored = {16'd0, val[15:0]};
      REG_ANG_LIMIT: stored = {16'd0, val[15:0]};
      REG_MAX_WAIT:  stored = (val < MAX_WAIT_MIN) ? MAX_WAIT_MIN : val;
      REG_INTERVAL:  stored = (val[15:0] < INTERVAL_MIN) ? {16'd0, INTERVAL_MIN}
                                                          : {16'd0, val[15:0]};
      default:       stored = val;
    endcase
    apb_xfer(1'b1, addr, val, got);
    case (idx)
      REG_LIN_LIMIT: lin_limit_cfg = stored[15:0];
      REG_ANG_LIMIT: ang_limit_cfg = stored[15:0];
      REG_HOLD:      hold_cfg      = stored;
      REG_POST:      post_cfg      = stored;
      REG_MAX_WAIT:  max_wait_cfg  = stored;
      REG_INTERVAL:  interval_cfg  = stored[15:0];
      default: ;
    endcase
    apb_xfer(1'b0, addr, '0, got);
    check_field($sformatf("register %0d readback", idx), stored, got);
  endtask

  // Drain every owed report, let queued bodies retire, then rewrite all registers
  task automatic reconfigure(input logic [31:0] lin, input logic [31:0] ang,
                             input logic [31:0] hold, input logic [31:0] post,
                             input logic [31:0] wait_ms, input logic [31:0] intv);
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write(REG_LIN_LIMIT, lin);
    cfg_write(REG_ANG_LIMIT, ang);
    cfg_write(REG_HOLD, hold);
    cfg_write(REG_POST, post);
    cfg_write(REG_MAX_WAIT, wait_ms);
    cfg_write(REG_INTERVAL, intv);
  endtask

  function automatic dir_row_t row(input logic [CMD_W-1:0] cmd, input logic [31:0] t,
                                   input logic [15:0] step, input logic [15:0] lin,
                                   input logic [15:0] ang, input bit live, input bit awake);
    dir_row_t d;
    d.req.cmd           = cmd;
    d.req.time_now      = t;
    d.req.step_ms       = step;
    d.req.linear_speed  = lin;
    d.req.angular_speed = ang;
    d.req.body_live     = live;
    d.req.body_awake    = awake;
    d.pinned            = 1'b0;
    d.report            = '0;
    return d;
  endfunction

  function automatic dir_row_t pin(input dir_row_t d, input msd_out_t rep);
    d.pinned = 1'b1;
    d.report = rep;
    return d;
  endfunction

  // Random settle sequences: mostly begin / bodies / tick runs, some noise and resets
  task automatic run_random(input int target);
    int goal;
    int kind;
    int nticks;
    int nbod;
    int pick;
    int lo;
    int hi;
    bit quiet;
    msd_in_t r;
    goal = work_items + target;
    while (work_items < goal) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 8) begin
        // noise: unused codes, dead bodies, stale marks, ticks at random times
        r = rand_item();
        case ($urandom_range(0, 3))
          0: r.cmd = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
          1: begin
            r.cmd       = CMD_BODY;
            r.body_live = 1'b0;
          end
          2: begin
            r.cmd      = CMD_MARK;
            r.time_now = last_activity_m - $urandom_range(0, 50);
          end
          default: r.cmd = CMD_TICK;
        endcase
        send(r);
      end else if (kind < 12) begin
        r          = rand_item();
        r.cmd      = CMD_RESET;
        r.time_now = ($urandom_range(0, 3) == 0) ? $urandom : world_ms;
        send(r);
      end else begin
        quiet = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 29) == 0) world_ms = $urandom;
        else world_ms += $urandom_range(0, 500);
        r          = rand_item();
        r.cmd      = CMD_BEGIN;
        r.time_now = world_ms;
        send(r);
        nticks = $urandom_range(1, 40);
        for (int t = 0; t < nticks; t++) begin
          nbod = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
          for (int b = 0; b < nbod; b++) begin
            r           = rand_item();
            r.cmd       = CMD_BODY;
            r.body_live = ($urandom_range(0, 9) != 0);
            if (quiet && $urandom_range(0, 19) != 0) begin
              r.linear_speed  = SPD_W'($urandom_range(0, lin_limit_cfg));
              r.angular_speed = SPD_W'($urandom_range(0, ang_limit_cfg));
            end else if ($urandom_range(0, 3) == 0) begin
              // right at the limit or one above it
              r.linear_speed  = lin_limit_cfg + SPD_W'($urandom_range(0, 1));
              r.angular_speed = ang_limit_cfg + SPD_W'($urandom_range(0, 1));
            end
            send(r);
          end
          if ($urandom_range(0, 19) == 0) begin
            r          = rand_item();
            r.cmd      = CMD_MARK;
            r.time_now = world_ms + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300));
            send(r);
          end
          r     = rand_item();
          r.cmd = CMD_TICK;
          pick  = $urandom_range(0, 99);
          if (pick < 60) begin
            lo = int'(interval_cfg / 2);
            hi = int'(interval_cfg) + int'(interval_cfg / 2);
            if (hi > 65535) hi = 65535;
            r.step_ms = STEP_W'($urandom_range(lo, hi));
          end else if (pick < 75) begin
            r.step_ms = '0;
          end else if (pick < 90) begin
            r.step_ms = STEP_W'($urandom_range(0, 65535));
          end else begin
            r.step_ms = STEP_W'($urandom_range(1, interval_cfg - 1));
          end
          if ($urandom_range(0, 19) == 0) world_ms = $urandom;
          else world_ms += TIME_W'(r.step_ms);
          r.time_now = world_ms;
          send(r);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall stretches, some long free runs
  // ---------------------------------------------------------------------------
  initial begin : stall_gen
    int free_len;
    int stall_len;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall <= 1'b0;
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      repeat (free_len - 1) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  // Check each accepted report against the oldest owed one
  always @(posedge clk) begin : report_check
    msd_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("report with none owed: status %0d elapsed %0d",
                                result.status, result.elapsed_ms));
      end else begin
        want = reports_due.pop_front();
        check_field("status", want.status, result.status);
        check_field("active_count", want.active_count, result.active_count);
        check_field("moving_count", want.moving_count, result.moving_count);
        check_field("awake_count", want.awake_count, result.awake_count);
        check_field("max_linear", want.max_linear, result.max_linear);
        check_field("max_angular", want.max_angular, result.max_angular);
        check_field("stable_ms", want.stable_ms, result.stable_ms);
        check_field("since_activity_ms", want.since_activity_ms, result.since_activity_ms);
        check_field("elapsed_ms", want.elapsed_ms, result.elapsed_ms);
      end
    end
  end

  // Abandon the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    msd_in_t r;
    rst         = 1'b1;
    item        = '0;
    item_valid  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    work_items  = 0;
    no_gaps     = 1'b0;
    world_ms    = 32'd5000;

    // predictor starts at the register defaults with all state cleared
    lin_limit_cfg   = LIN_LIMIT_RST;
    ang_limit_cfg   = ANG_LIMIT_RST;
    hold_cfg        = HOLD_RST;
    post_cfg        = POST_RST;
    max_wait_cfg    = MAX_WAIT_RST;
    interval_cfg    = INTERVAL_RST;
    settling_m      = 1'b0;
    last_activity_m = '0;
    start_m         = '0;
    accum_m         = '0;
    stable_m        = '0;
    shown_m         = '0;
    drop_pending();

    // Directed rows at default registers (limits 5, hold 500, post 250, wait 10000,
    // interval 100). Typed-in reports only where they follow at a glance.
    directed_rows.push_back(pin(row(CMD_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 1, 0), '0));
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 0, 1));
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1, 1));
    // not settling: pending bodies are dropped, summary stays clear
    directed_rows.push_back(pin(row(CMD_TICK, 32'd50, 16'hFFFF, 16'd0, 16'd0, 0, 0), '0));
    directed_rows.push_back(row(CMD_BAD_FIRST, 32'd7, 16'd1, 16'd1, 16'd1, 1, 1));
    directed_rows.push_back(row(CMD_BAD_FIRST + 3'd1, 32'd7, 16'd1, 16'd1, 16'd1, 1, 1));
    directed_rows.push_back(row(CMD_BAD_LAST, 32'd7, 16'd1, 16'd1, 16'd1, 1, 1));
    directed_rows.push_back(row(CMD_BEGIN, 32'd1000, 16'd0, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'd3, 16'd2, 1, 1));
    // speeds equal to the limit do not count as moving
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'd5, 16'd5, 1, 0));
    // preloaded accumulator samples on the first tick after begin
    directed_rows.push_back(pin(row(CMD_TICK, 32'd1000, 16'd0, 16'd0, 16'd0, 0, 0),
                                msd_out_t'{ST_MONITOR, 10'd2, 10'd0, 10'd1, 16'd5, 16'd5,
                                           32'd100, 32'd0, 32'd0}));
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'd6, 16'd0, 1, 1));
    directed_rows.push_back(row(CMD_TICK, 32'd1040, 16'd40, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_MARK, 32'd500, 16'd0, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_MARK, 32'd1100, 16'd0, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_TICK, 32'd1200, 16'd60, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_TICK, 32'd1600, 16'hFFFF, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_BODY, 32'd0, 16'd0, 16'd0, 16'hFFFF, 1, 0));
    directed_rows.push_back(row(CMD_TICK, 32'd1700, 16'd100, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_TICK, 32'd0, 16'd5, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(row(CMD_RESET, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 0, 0));
    directed_rows.push_back(pin(row(CMD_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 0, 0), '0));
    directed_rows.push_back(row(CMD_MARK, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 0, 0));

    // hold reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_pinned(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].report);

    run_random(200);

    // low extremes: zero limits, clamped wait and interval
    reconfigure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(150);

    // high extremes: nothing moves, never settles, never times out
    reconfigure(32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
    run_random(150);

    // Saturation: overfill the body counters in a single sample.
    reconfigure(32'd100, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd9);
    no_gaps    = 1'b1;
    r          = rand_item();
    r.cmd      = CMD_BEGIN;
    r.time_now = world_ms;
    send(r);
    repeat (1030) begin
      r               = rand_item();
      r.cmd           = CMD_BODY;
      r.body_live     = 1'b1;
      r.body_awake    = 1'b1;
      r.linear_speed  = 16'hFFFF;
      send(r);
    end
    r          = rand_item();
    r.cmd      = CMD_TICK;
    r.time_now = world_ms;
    r.step_ms  = 16'd10;
    send(r);
    no_gaps = 1'b0;

    reconfigure($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 2000),
                $urandom_range(0, 1000), $urandom_range(100, 20000), $urandom_range(10, 300));
    run_random(200);

    // just below both clamps
    reconfigure(32'd1, 32'd65534, 32'd1, 32'd1, 32'd99, 32'd9);
    run_random(150);

    // wait out every owed report, then give stray reports time to show
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
